// ----- design/sha_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies; sha_msg_sched, sha_round_core and the top level refer to this package.
package sha_pkg;

  // Block and length geometry
  localparam int unsigned FILL_W = 6;                 // byte position within a 64-byte block
  localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;    // last byte slot of a block
  localparam logic [FILL_W-1:0] LEN_POS = 6'd56;      // first slot of the length field
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [63:0] BIT_INC = 64'd8;            // bits added per message byte

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  // Control toward the message schedule window
  typedef struct packed {
    logic       shift_byte;
    logic       step;
    logic [7:0] byte_in;
  } sched_ctl_t;

  // Control toward the compression core
  typedef struct packed {
    logic       load_work;
    logic       do_round;
    logic       add_hash;
    logic       init_iv;
    logic [5:0] rnd;
  } core_ctl_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Compression sigmas
  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Schedule sigmas
  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ----- design/sha_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: message byte beats in, digest word beats out.
// Standalone; used by the top level sha256_stream_hasher.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  input ready);
  modport sink (input valid, input data_byte, input byte_valid, input last,
                output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        word_last;

  modport source (output valid, output digest_word, output word_last, input ready);
  modport sink (input valid, input digest_word, input word_last, output ready);
endinterface

// ----- design/sha_msg_sched.sv -----
`timescale 1ns / 1ps
// Message block buffer and schedule window: bytes shift in while filling,
// then the same 16-word window slides one word per round. Uses sha_pkg.
module sha_msg_sched (
  input  logic                clk,
  input  sha_pkg::sched_ctl_t ctl,
  output logic [31:0]         w_cur
);

  logic [511:0] win_r;
  logic [511:0] win_nxt;
  logic [31:0]  w_new;

  // Word i of the window sits at win_r[511-32*i -: 32]
  assign w_cur = win_r[511:480];

  // Next schedule word from words 0, 1, 9 and 14
  always_comb begin
    w_new = sha_pkg::small_sigma1(win_r[63:32]) + win_r[223:192] +
            sha_pkg::small_sigma0(win_r[479:448]) + win_r[511:480];
  end

  always_comb begin
    win_nxt = win_r;
    if (ctl.shift_byte) begin
      win_nxt = {win_r[503:0], ctl.byte_in};
    end else if (ctl.step) begin
      win_nxt = {win_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

// ----- design/sha_round_core.sv -----
`timescale 1ns / 1ps
// Compression core: working variables a..h with one round unit, plus the
// chaining value that each block is added into. Uses sha_pkg.
module sha_round_core (
  input  logic               clk,
  input  logic               rst_n,
  input  sha_pkg::core_ctl_t ctl,
  input  logic [31:0]        w_cur,
  input  logic [2:0]         word_sel,
  output logic [31:0]        hash_word
);

  logic [31:0] work_r [8];
  logic [31:0] work_nxt [8];
  logic [31:0] hash_r [8];
  logic [31:0] hash_nxt [8];
  logic [31:0] t1;
  logic [31:0] t2;

  assign hash_word = hash_r[word_sel];

  // Round unit
  always_comb begin
    t1 = work_r[7] + sha_pkg::big_sigma1(work_r[4]) +
         sha_pkg::choose(work_r[4], work_r[5], work_r[6]) +
         sha_pkg::ROUND_K[ctl.rnd] + w_cur;
    t2 = sha_pkg::big_sigma0(work_r[0]) + sha_pkg::majority(work_r[0], work_r[1], work_r[2]);
  end

  // Working variables
  always_comb begin
    work_nxt = work_r;
    if (ctl.load_work) begin
      work_nxt = hash_r;
    end else if (ctl.do_round) begin
      work_nxt[7] = work_r[6];
      work_nxt[6] = work_r[5];
      work_nxt[5] = work_r[4];
      work_nxt[4] = work_r[3] + t1;
      work_nxt[3] = work_r[2];
      work_nxt[2] = work_r[1];
      work_nxt[1] = work_r[0];
      work_nxt[0] = t1 + t2;
    end
  end

  // Chaining value
  always_comb begin
    hash_nxt = hash_r;
    if (ctl.init_iv) begin
      hash_nxt = sha_pkg::HASH_IV;
    end else if (ctl.add_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_nxt[i] = hash_r[i] + work_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= sha_pkg::HASH_IV;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

// ----- design/sha256_stream_hasher.sv -----
`timescale 1ns / 1ps
// Top level: SHA-256 over a byte stream, sequencer plus padding logic.
// Depends on sha_pkg, sha_if, sha_msg_sched and sha_round_core.
//
//   port    | dir | beat payload                        | handshake
//   --------+-----+-------------------------------------+-------------
//   in_ch   | in  | data_byte[7:0], byte_valid, last    | valid/ready
//   out_ch  | out | digest_word[31:0], word_last        | valid/ready
//
// Byte beats are accepted one per cycle while idle. When a block fills, input stalls through
// the 64 rounds in the single round unit and the add into the chaining value.
// A last beat starts padding, one pad byte shifted per cycle to the block end, then
// one or two compressions, then eight digest beats; ready stays low until the eighth
// is taken. Output stalls simply hold the current digest word.
// Synchronous active-low reset returns the block to an empty message.
module sha256_stream_hasher (
  input logic        clk,
  input logic        rst_n,
  sha_in_if.sink     in_ch,
  sha_out_if.source  out_ch
);

  sha_pkg::state_t     state_r, state_nxt;
  logic [5:0]          fill_r, fill_nxt;
  logic [63:0]         len_r, len_nxt;
  logic                last_pend_r, last_pend_nxt;
  logic                mark_r, mark_nxt;       // 0x80 already placed
  logic                len_ok_r, len_ok_nxt;   // length field goes into this block
  logic [5:0]          rnd_r, rnd_nxt;
  logic [2:0]          oidx_r, oidx_nxt;
  logic                in_acc;
  logic                out_acc;
  logic [7:0]          pad_byte;
  logic [31:0]         w_cur;
  logic [31:0]         hash_word;
  sha_pkg::sched_ctl_t sched_ctl;
  sha_pkg::core_ctl_t  core_ctl;

  // Handshakes
  assign in_ch.ready        = (state_r == sha_pkg::ST_IDLE);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = (state_r == sha_pkg::ST_OUT);
  assign out_ch.digest_word = hash_word;
  assign out_ch.word_last   = (oidx_r == sha_pkg::LAST_WORD);
  assign out_acc            = out_ch.valid && out_ch.ready;

  // Padding byte: marker, zeros, then the bit length MSB first
  always_comb begin
    pad_byte = 8'h00;
    if (!mark_r) begin
      pad_byte = sha_pkg::PAD_MARK;
    end else if (len_ok_r && (fill_r >= sha_pkg::LEN_POS)) begin
      pad_byte = len_r[{~fill_r[2:0], 3'b000} +: 8];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    last_pend_nxt = last_pend_r;
    mark_nxt      = mark_r;
    len_ok_nxt    = len_ok_r;
    rnd_nxt       = rnd_r;
    oidx_nxt      = oidx_r;
    sched_ctl     = '0;
    core_ctl      = '0;
    core_ctl.rnd  = rnd_r;

    case (state_r)
      sha_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.last) begin
            last_pend_nxt = 1'b1;
            state_nxt     = sha_pkg::ST_PAD;
          end
          if (in_ch.byte_valid) begin
            sched_ctl.shift_byte = 1'b1;
            sched_ctl.byte_in    = in_ch.data_byte;
            fill_nxt             = fill_r + 6'd1;
            len_nxt              = len_r + sha_pkg::BIT_INC;
            if (fill_r == sha_pkg::FILL_LAST) begin
              core_ctl.load_work = 1'b1;
              rnd_nxt            = '0;
              state_nxt          = sha_pkg::ST_ROUND;
            end
          end
        end
      end

      sha_pkg::ST_PAD: begin
        sched_ctl.shift_byte = 1'b1;
        sched_ctl.byte_in    = pad_byte;
        fill_nxt             = fill_r + 6'd1;
        if (!mark_r) begin
          mark_nxt   = 1'b1;
          len_ok_nxt = (fill_r < sha_pkg::LEN_POS);
        end
        if (fill_r == sha_pkg::FILL_LAST) begin
          core_ctl.load_work = 1'b1;
          rnd_nxt            = '0;
          state_nxt          = sha_pkg::ST_ROUND;
        end
      end

      sha_pkg::ST_ROUND: begin
        core_ctl.do_round = 1'b1;
        sched_ctl.step    = 1'b1;
        rnd_nxt           = rnd_r + 6'd1;
        if (rnd_r == sha_pkg::LAST_ROUND) begin
          state_nxt = sha_pkg::ST_ADD;
        end
      end

      sha_pkg::ST_ADD: begin
        core_ctl.add_hash = 1'b1;
        if (!last_pend_r) begin
          state_nxt = sha_pkg::ST_IDLE;
        end else if (mark_r && len_ok_r) begin
          oidx_nxt  = '0;
          state_nxt = sha_pkg::ST_OUT;
        end else begin
          // marker block done without room for the length: one more block
          len_ok_nxt = 1'b1;
          state_nxt  = sha_pkg::ST_PAD;
        end
      end

      sha_pkg::ST_OUT: begin
        if (out_acc) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == sha_pkg::LAST_WORD) begin
            core_ctl.init_iv = 1'b1;
            fill_nxt         = '0;
            len_nxt          = '0;
            last_pend_nxt    = 1'b0;
            mark_nxt         = 1'b0;
            len_ok_nxt       = 1'b0;
            state_nxt        = sha_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = sha_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha_pkg::ST_IDLE;
      fill_r      <= '0;
      len_r       <= '0;
      last_pend_r <= 1'b0;
      mark_r      <= 1'b0;
      len_ok_r    <= 1'b0;
      rnd_r       <= '0;
      oidx_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      last_pend_r <= last_pend_nxt;
      mark_r      <= mark_nxt;
      len_ok_r    <= len_ok_nxt;
      rnd_r       <= rnd_nxt;
      oidx_r      <= oidx_nxt;
    end
  end

  sha_msg_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_cur (w_cur)
  );

  sha_round_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (core_ctl),
    .w_cur     (w_cur),
    .word_sel  (oidx_r),
    .hash_word (hash_word)
  );

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while digest beats pending");

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last) |=> !in_ch.ready)
    else $error("input not stalled after last beat");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha_pkg::ST_ROUND && rnd_r == sha_pkg::LAST_ROUND) |=>
      (state_r == sha_pkg::ST_ADD))
    else $error("round sequence did not end in the add step");

  a_digest_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.word_last) |=>
      (state_r == sha_pkg::ST_IDLE && fill_r == '0 && len_r == '0))
    else $error("message state not cleared after final digest beat");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sha256_stream_hasher: byte beats in, digest word beats out.
// Depends on design/sha_if.sv and the design files; holds its own SHA-256 predictor.
module testbench;

  // Run control
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int unsigned DRAIN_CYCLES = 300;     // covers padding plus two compressions
  localparam int unsigned RANDOM_BEATS = 40;
  localparam int unsigned RANDOM_MSGS_MIN = 2;
  localparam int unsigned MAX_REPORTS = 10;

  // Message framing
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_SLOT = 56;          // length field starts here
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef logic [7:0] byte_q_t [$];

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_stream_hasher DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predictor state
  logic [31:0] sha_chain [8];
  logic [7:0]  msg_block [64];
  int unsigned msg_fill;
  logic [63:0] msg_bits;     // wraps mod 2^64 like the hardware counter
  digest_beat_t expected_digest [$];

  // Run bookkeeping
  bit          idle_on = 1'b1;
  int unsigned error_count = 0;
  int unsigned words_checked = 0;
  int unsigned messages_hashed = 0;
  int unsigned hashed_beats = 0;
  int unsigned quiet_cycles = 0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of msg_block into sha_chain
  function automatic void hash_compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    a = sha_chain[0]; b = sha_chain[1]; c = sha_chain[2]; d = sha_chain[3];
    e = sha_chain[4]; f = sha_chain[5]; g = sha_chain[6]; h = sha_chain[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + SHA_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    sha_chain[0] += a; sha_chain[1] += b; sha_chain[2] += c; sha_chain[3] += d;
    sha_chain[4] += e; sha_chain[5] += f; sha_chain[6] += g; sha_chain[7] += h;
  endfunction

  function automatic void hash_restart();
    foreach (sha_chain[i]) sha_chain[i] = SHA_IV[i];
    foreach (msg_block[i]) msg_block[i] = 8'h00;
    msg_fill = 0;
    msg_bits = '0;
  endfunction

  // Fold one accepted input beat into the predictor; a last beat queues the digest
  function automatic void hash_absorb_beat(input logic [7:0] b, input logic bv,
                                           input logic lst);
    digest_beat_t exp_beat;
    if (bv) begin
      msg_block[msg_fill] = b;
      msg_fill++;
      msg_bits += BITS_PER_BYTE;
      if (msg_fill == BLOCK_BYTES) begin
        hash_compress_block();
        msg_fill = 0;
      end
    end
    if (lst) begin
      msg_block[msg_fill] = PAD_BYTE;
      for (int i = msg_fill + 1; i < BLOCK_BYTES; i++) msg_block[i] = 8'h00;
      // long tail: no room for the length, spill into a second block
      if (msg_fill >= LEN_SLOT) begin
        hash_compress_block();
        foreach (msg_block[i]) msg_block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_block[LEN_SLOT + i] = msg_bits[63 - 8*i -: 8];
      hash_compress_block();
      for (int i = 0; i < 8; i++) begin
        exp_beat.word = sha_chain[i];
        exp_beat.last = (i == 7);
        expected_digest.insert(expected_digest.size(), exp_beat);
      end
      hash_restart();
    end
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic byte_q_t random_bytes(input int unsigned len);
    byte_q_t q;
    for (int k = 0; k < len; k++) q.insert(q.size(), 8'($urandom_range(0, 255)));
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Drive one input beat at the falling edge, hold until accepted
  task automatic send_beat(input logic [7:0] b, input logic bv, input logic lst);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.byte_valid <= bv;
    in_ch.last       <= lst;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    hash_absorb_beat(b, bv, lst);
    @(negedge clk);
  endtask

  // Whole message; the final byte rides on the last beat or a separate empty last follows
  task automatic send_message(input byte_q_t msg, input bit carry_last, input bit add_noise);
    int unsigned len;
    len = msg.size();
    for (int k = 0; k < len; k++) begin
      if (add_noise && $urandom_range(0, 11) == 0)
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(msg[k], 1'b1, carry_last && (k == len - 1));
      hashed_beats++;
    end
    if (!carry_last || len == 0) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      hashed_beats++;
    end
    messages_hashed++;
  endtask

  // Short known messages, both last-beat forms, ignored beats, byte extremes
  task automatic test_known_messages();
    byte_q_t msg;
    msg = {};
    send_message(msg, 1'b0, 1'b0);               // empty message
    msg = '{8'h61, 8'h62, 8'h63};
    send_message(msg, 1'b1, 1'b0);               // "abc", last carries 'c'
    send_beat(8'hFF, 1'b0, 1'b0);                // ignored beat
    send_message(msg, 1'b0, 1'b0);               // "abc", separate empty last
    msg = '{8'hFF};
    send_message(msg, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    msg = '{8'h00};
    send_message(msg, 1'b0, 1'b0);
    msg = '{8'hFF, 8'h00, 8'hA5, 8'h5A};
    send_message(msg, 1'b1, 1'b0);
  endtask

  // Lengths around the length-field slot and the block end
  task automatic test_padding_boundaries();
    int unsigned lens [3] = '{56, 63, 64};
    foreach (lens[i]) send_message(random_bytes(lens[i]), 1'($urandom_range(0, 1)), 1'b0);
  endtask

  // Random lengths and content, idling on or off per message
  task automatic test_random_messages();
    int unsigned edge_lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    int unsigned start_beats, start_msgs, len, roll;
    start_beats = hashed_beats;
    start_msgs = messages_hashed;
    while (hashed_beats - start_beats < RANDOM_BEATS ||
           messages_hashed - start_msgs < RANDOM_MSGS_MIN) begin
      roll = $urandom_range(0, 9);
      if (roll < 4)       len = $urandom_range(0, 40);
      else if (roll < 6)  len = $urandom_range(41, 80);
      else if (roll < 8)  len = edge_lens[$urandom_range(0, 7)];
      else if (roll == 8) len = $urandom_range(81, 140);
      else                len = $urandom_range(0, 3);
      idle_on = ($urandom_range(0, 3) != 0);
      send_message(random_bytes(len), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    idle_on = 1'b1;
  endtask

  // Compare one digest beat against the oldest expectation
  task automatic check_digest_beat(input logic [31:0] got_word, input logic got_last);
    digest_beat_t want;
    words_checked++;
    if (expected_digest.size() == 0) begin
      report_mismatch($sformatf("digest beat %h last=%b with nothing expected",
                                got_word, got_last));
    end else begin
      want = expected_digest.pop_front();
      if (got_word !== want.word || got_last !== want.last)
        report_mismatch($sformatf("digest word exp %h last=%b, got %h last=%b",
                                  want.word, want.last, got_word, got_last));
    end
  endtask

  // Output ready: random stalls when idling is on
  initial begin : result_backpressure
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Result checking and watchdog
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      check_digest_beat(out_ch.digest_word, out_ch.word_last);
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles, %0d digest words outstanding",
               quiet_cycles, expected_digest.size());
      $display("** sha256_stream_hasher: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.byte_valid = 1'b0;
    in_ch.last       = 1'b0;
    hash_restart();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_known_messages();
    test_padding_boundaries();
    test_random_messages();
    in_ch.valid <= 1'b0;

    // let every digest come out, then watch for stray beats
    while (expected_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages over %0d data/last beats (empty, one- and two-block tails)",
             messages_hashed, hashed_beats);
    $display("Checked %0d digest words, %0d mismatches", words_checked, error_count);
    if (error_count == 0)
      $display("** sha256_stream_hasher: PASSED **");
    else
      $display("** sha256_stream_hasher: FAILED **");
    $finish;
  end

endmodule
